FILE: rtl/core/stli_pkg.sv
// Package for the sorted table linear interpolator.
// Holds table sizing, status and kind codes, the command and result words,
// and the structs that pass between the cells and the control logic.
`default_nettype none
package stli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Divide steps per value: |value| << 16 is a 48-bit dividend
  localparam int DIV_STEPS   = 48;
  localparam int DSTEP_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_EVAL   = 2'd1;
  localparam logic [1:0] KIND_DIVIDE = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] sample_value;
    logic signed [31:0] divisor;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [31:0]        max_magnitude;
    logic [2:0]         status;
  } result_word_t;

  // Operation wave that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic               active;
    logic               ins;       // insert in progress
    logic               ev;        // evaluate in progress
    logic               probe;     // table full: look for duplicate only
    logic               carry;     // insert word still to be placed
    logic               disp;      // insert has displaced an entry
    logic               dup;
    logic               found;
    logic               exact;
    logic               have_prev;
    logic signed [31:0] x;
    logic signed [31:0] ck;
    logic signed [31:0] cv;
    logic signed [31:0] pk;
    logic signed [31:0] pv;
    logic signed [31:0] fk;
    logic signed [31:0] fv;
    logic [31:0]        maxm;
  } wave_t;

  // Broadcast control of the per-cell divide
  typedef struct packed {
    logic        load;
    logic        step;
    logic        finish;
    logic        dneg;
    logic [31:0] dm;
  } div_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/stli_cell.sv
// One table cell: holds one key/value pair and passes the operation wave on.
// Also runs its own bit-serial divide under broadcast control. Uses stli_pkg.
`default_nettype none
module stli_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [stli_pkg::IDX_W-1:0] idx,
  input  wire logic [stli_pkg::CNT_W-1:0] count,
  input  wire stli_pkg::div_ctl_t       dctl,
  input  wire stli_pkg::wave_t          w_in,
  output stli_pkg::wave_t               w_out
);

  logic signed [31:0] key;
  logic signed [31:0] value;
  logic signed [31:0] key_next;
  logic signed [31:0] value_next;
  logic [31:0]        rem;
  logic [47:0]        num;
  logic               neg;
  stli_pkg::wave_t    w_next;
  logic               valid;
  logic               incl;
  logic [31:0]        abs_v;
  logic [31:0]        abs_in;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        sat_q;

  assign valid = count > (stli_pkg::CNT_W)'(idx);

  // Wave step through this cell
  always_comb begin
    w_next     = w_in;
    key_next   = key;
    value_next = value;
    incl       = valid;
    if (w_in.active) begin
      if (w_in.ins && w_in.carry) begin
        if (valid) begin
          if (w_in.disp) begin
            key_next   = w_in.ck;
            value_next = w_in.cv;
            w_next.ck  = key;
            w_next.cv  = value;
          end else if (key == w_in.ck) begin
            w_next.dup   = 1'b1;
            w_next.carry = 1'b0;
          end else if (key > w_in.ck) begin
            if (w_in.probe) begin
              w_next.carry = 1'b0;
            end else begin
              key_next    = w_in.ck;
              value_next  = w_in.cv;
              w_next.ck   = key;
              w_next.cv   = value;
              w_next.disp = 1'b1;
            end
          end
        end else if (!w_in.probe) begin
          key_next     = w_in.ck;
          value_next   = w_in.cv;
          incl         = 1'b1;
          w_next.carry = 1'b0;
        end
      end
      if (w_in.ev && !w_in.found && valid) begin
        if (key >= w_in.x) begin
          w_next.found = 1'b1;
          w_next.fk    = key;
          w_next.fv    = value;
          w_next.exact = (key == w_in.x);
        end else begin
          w_next.pk        = key;
          w_next.pv        = value;
          w_next.have_prev = 1'b1;
        end
      end
      abs_v = value_next[31] ? (~value_next + 32'd1) : value_next;
      if (incl && (abs_v > w_in.maxm)) begin
        w_next.maxm = abs_v;
      end
    end else begin
      abs_v = 32'd0;
    end
  end

  // Divide datapath
  assign abs_in = value[31] ? (~value + 32'd1) : value;
  assign trial  = {rem, num[47]};
  assign qbit   = trial >= {1'b0, dctl.dm};
  always_comb begin
    if (neg) begin
      sat_q = (num > 48'h0000_8000_0000) ? 32'h8000_0000 : (~num[31:0] + 32'd1);
    end else begin
      sat_q = (num > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : num[31:0];
    end
  end

  // Entry and divide registers
  always_ff @(posedge clk) begin
    if (dctl.load) begin
      rem <= 32'd0;
      num <= {abs_in, 16'd0};
      neg <= value[31] ^ dctl.dneg;
    end else if (dctl.step) begin
      rem <= qbit ? 32'(trial - {1'b0, dctl.dm}) : trial[31:0];
      num <= {num[46:0], qbit};
    end
    if (dctl.finish) begin
      value <= sat_q;
    end else if (w_in.active) begin
      key   <= key_next;
      value <= value_next;
    end
  end

  // Wave register to the next cell
  always_ff @(posedge clk) begin
    w_out <= w_next;
    if (rst) begin
      w_out.active <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/stli_interp.sv
// Interpolation unit: y1 + sign(dy) * (|dy| * (x - x1)) / (x2 - x1).
// Shift-add multiply, then restoring divide, one bit per cycle. Uses stli_pkg.
`default_nettype none
module stli_interp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] x,
  input  wire logic signed [31:0] x1,
  input  wire logic signed [31:0] x2,
  input  wire logic signed [31:0] y1,
  input  wire logic signed [31:0] y2,
  output logic                    done,
  output logic signed [31:0]      result
);

  typedef enum logic [1:0] {I_IDLE, I_MUL, I_DIV} istate_t;

  istate_t            state;
  logic [6:0]         cnt;
  logic [63:0]        p;
  logic [31:0]        mag;
  logic [31:0]        span;
  logic [31:0]        rem;
  logic signed [31:0] base;
  logic               neg;
  logic signed [32:0] dy;
  logic [32:0]        msum;
  logic [32:0]        trial;
  logic               qbit;
  logic signed [32:0] fin;

  assign dy    = 33'(y2) - 33'(y1);
  assign msum  = {1'b0, p[63:32]} + (p[0] ? {1'b0, mag} : 33'd0);
  assign trial = {rem, p[63]};
  assign qbit  = trial >= {1'b0, span};
  assign fin   = neg ? (33'(base) - {1'b0, p[31:0]}) : (33'(base) + {1'b0, p[31:0]});

  // Multiply then divide sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        I_IDLE: begin
          if (start) begin
            neg   <= dy[32];
            mag   <= dy[32] ? 32'(-dy) : dy[31:0];
            span  <= 32'(x2 - x1);
            base  <= y1;
            p     <= {32'd0, 32'(x - x1)};
            cnt   <= 7'd0;
            state <= I_MUL;
          end
        end
        I_MUL: begin
          p   <= {msum, p[31:1]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            cnt   <= 7'd0;
            rem   <= 32'd0;
            state <= I_DIV;
          end
        end
        I_DIV: begin
          rem <= qbit ? 32'(trial - {1'b0, span}) : trial[31:0];
          p   <= {p[62:0], qbit};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= I_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  assign result = fin[31:0];

endmodule
`default_nettype wire

FILE: rtl/core/sorted_table_linear_interpolator.sv
// Top level of the sorted table linear interpolator.
// Builds the cell chain from stli_cell, the stli_interp unit, and control.
//
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown for one cycle with done high. Every command
// sends a wave down the chain of TABLE_DEPTH cells, one cell per cycle,
// so insert, table-full, duplicate and plain results are formed as the
// wave leaves the last cell. A nonzero divide first runs a 48-step divide
// in all cells at once. An evaluate that falls between two keys adds the
// interpolation unit: 32 multiply steps and 64 divide steps. The receiver
// cannot stall the result.
`default_nettype none
module sorted_table_linear_interpolator (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire stli_pkg::cmd_word_t    cmd,
  output logic                        busy,
  output logic                        done,
  output stli_pkg::result_word_t      result
);

  typedef enum logic [2:0] {S_IDLE, S_DLOAD, S_DSTEP, S_DFIN, S_WAVE, S_INTERP} state_t;

  state_t                       state;
  stli_pkg::cmd_word_t          cmd_q;
  logic [stli_pkg::CNT_W-1:0]   count;
  logic [stli_pkg::DSTEP_W-1:0] dcnt;
  logic [31:0]                  max_hold;
  stli_pkg::wave_t              launch;
  stli_pkg::wave_t              w [stli_pkg::TABLE_DEPTH+1];
  stli_pkg::wave_t              tail;
  stli_pkg::div_ctl_t           dctl;
  logic                         i_start;
  logic                         i_done;
  logic signed [31:0]           i_result;
  logic                         full;

  assign busy = (state != S_IDLE);
  assign full = (count == (stli_pkg::CNT_W)'(stli_pkg::TABLE_DEPTH));
  assign w[0] = launch;
  assign tail = w[stli_pkg::TABLE_DEPTH];

  // Divide control broadcast to every cell
  always_comb begin
    dctl.load   = (state == S_DLOAD);
    dctl.step   = (state == S_DSTEP);
    dctl.finish = (state == S_DFIN);
    dctl.dneg   = cmd_q.divisor[31];
    dctl.dm     = cmd_q.divisor[31] ? (~cmd_q.divisor + 32'd1) : cmd_q.divisor;
  end

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < stli_pkg::TABLE_DEPTH; g++) begin : g_cell
      stli_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .idx   ((stli_pkg::IDX_W)'(g)),
        .count (count),
        .dctl  (dctl),
        .w_in  (w[g]),
        .w_out (w[g+1])
      );
    end
  endgenerate

  stli_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (i_start),
    .x      (tail.x),
    .x1     (tail.pk),
    .x2     (tail.fk),
    .y1     (tail.pv),
    .y2     (tail.fv),
    .done   (i_done),
    .result (i_result)
  );

  assign i_start = (state == S_WAVE) && tail.active && tail.ev && (count != '0) &&
                   tail.found && tail.have_prev && !tail.exact;

  // Control sequencer and result word
  always_ff @(posedge clk) begin
    done          <= 1'b0;
    launch.active <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            if ((cmd.kind == stli_pkg::KIND_DIVIDE) && (cmd.divisor != 32'sd0)) begin
              state <= S_DLOAD;
            end else begin
              launch           <= '0;
              launch.active    <= 1'b1;
              launch.ins       <= (cmd.kind == stli_pkg::KIND_INSERT);
              launch.carry     <= (cmd.kind == stli_pkg::KIND_INSERT);
              launch.ev        <= (cmd.kind == stli_pkg::KIND_EVAL);
              launch.probe     <= full;
              launch.x         <= cmd.key;
              launch.ck        <= cmd.key;
              launch.cv        <= cmd.sample_value;
              state            <= S_WAVE;
            end
          end
        end
        S_DLOAD: begin
          dcnt  <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          dcnt <= dcnt + (stli_pkg::DSTEP_W)'(1);
          if (dcnt == (stli_pkg::DSTEP_W)'(stli_pkg::DIV_STEPS - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          launch        <= '0;
          launch.active <= 1'b1;
          state         <= S_WAVE;
        end
        S_WAVE: begin
          if (tail.active) begin
            max_hold                    <= tail.maxm;
            result.max_magnitude        <= tail.maxm;
            result.result_value         <= 32'sd0;
            result.status               <= stli_pkg::ST_OK;
            if (tail.ins) begin
              if (tail.dup) begin
                result.status <= stli_pkg::ST_DUP;
              end else if (tail.probe) begin
                result.status <= stli_pkg::ST_FULL;
              end else begin
                count <= count + (stli_pkg::CNT_W)'(1);
              end
            end else if (tail.ev) begin
              if (count == '0) begin
                result.status <= stli_pkg::ST_EMPTY;
              end else if (!tail.found) begin
                result.result_value <= tail.pv;
              end else if (!tail.have_prev || tail.exact) begin
                result.result_value <= tail.fv;
              end
            end else if ((cmd_q.kind == stli_pkg::KIND_DIVIDE) &&
                         (cmd_q.divisor == 32'sd0)) begin
              result.status <= stli_pkg::ST_DIV0;
            end
            if (i_start) begin
              state <= S_INTERP;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_INTERP: begin
          if (i_done) begin
            result.result_value  <= i_result;
            result.max_magnitude <= max_hold;
            result.status        <= stli_pkg::ST_OK;
            done                 <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on sequencing
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (stli_pkg::CNT_W)'(stli_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_idle_no_wave: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !tail.active)
    else $error("wave left the chain while idle");
  a_interp_owned: assert property (@(posedge clk) disable iff (rst)
    i_done |-> (state == S_INTERP))
    else $error("interpolation finished outside its phase");

endmodule
`default_nettype wire

FILE: dv/tb_sorted_table_linear_interpolator.sv
// Testbench for the sorted table linear interpolator.
// Drives command words, predicts each result word from a local table model,
// and depends on stli_pkg and the sorted_table_linear_interpolator top level.
module tb_sorted_table_linear_interpolator;

  // Kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   start;
  stli_pkg::cmd_word_t    cmd;
  logic                   busy;
  logic                   done;
  stli_pkg::result_word_t result;

  sorted_table_linear_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  // Local copy of the table
  logic signed [31:0] tbl_key [stli_pkg::TABLE_DEPTH];
  logic signed [31:0] tbl_val [stli_pkg::TABLE_DEPTH];
  int                 tbl_count;

  stli_pkg::result_word_t expected_words[$];
  int           mismatch_count;
  int           unmatched_count;
  int           cycle_count;
  int           send_gap_pct;

  localparam int CYCLE_LIMIT = 1500000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // First index whose key is not below x
  function automatic int find_slot(logic signed [31:0] x);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] >= x) return i;
    end
    return tbl_count;
  endfunction

  function automatic logic [31:0] table_peak();
    logic [31:0] m;
    logic [31:0] a;
    m = 0;
    for (int i = 0; i < tbl_count; i++) begin
      a = tbl_val[i][31] ? (~tbl_val[i] + 32'd1) : tbl_val[i];
      if (a > m) m = a;
    end
    return m;
  endfunction

  // Apply one command to the local table and return the predicted word
  function automatic stli_pkg::result_word_t apply_command(stli_pkg::cmd_word_t c);
    stli_pkg::result_word_t r;
    int pos;
    longint x1, x2, y1, y2, dy, dm, v, rr;
    longint unsigned mag, q;
    r = '0;
    r.status = stli_pkg::ST_OK;
    case (c.kind)
      stli_pkg::KIND_INSERT: begin
        pos = find_slot(c.key);
        if (pos < tbl_count && tbl_key[pos] == c.key) begin
          r.status = stli_pkg::ST_DUP;
        end else if (tbl_count >= stli_pkg::TABLE_DEPTH) begin
          r.status = stli_pkg::ST_FULL;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = c.key;
          tbl_val[pos] = c.sample_value;
          tbl_count++;
        end
      end
      stli_pkg::KIND_EVAL: begin
        if (tbl_count == 0) begin
          r.status = stli_pkg::ST_EMPTY;
        end else begin
          pos = find_slot(c.key);
          if (pos == 0) r.result_value = tbl_val[0];
          else if (pos >= tbl_count) r.result_value = tbl_val[tbl_count-1];
          else if (tbl_key[pos] == c.key) r.result_value = tbl_val[pos];
          else begin
            x1 = tbl_key[pos-1];
            x2 = tbl_key[pos];
            y1 = tbl_val[pos-1];
            y2 = tbl_val[pos];
            dy = y2 - y1;
            mag = dy < 0 ? -dy : dy;
            q = mag * longint'(c.key - x1) / longint'(x2 - x1);
            rr = dy < 0 ? y1 - longint'(q) : y1 + longint'(q);
            r.result_value = rr[31:0];
          end
        end
      end
      stli_pkg::KIND_DIVIDE: begin
        if (c.divisor == 0) begin
          r.status = stli_pkg::ST_DIV0;
        end else begin
          dm = c.divisor;
          if (dm < 0) dm = -dm;
          for (int i = 0; i < tbl_count; i++) begin
            v = tbl_val[i];
            mag = (v < 0 ? -v : v) << 16;
            q = mag / longint'(dm);
            if ((v < 0) != (c.divisor < 0))
              rr = q > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(q);
            else
              rr = q > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(q);
            tbl_val[i] = rr[31:0];
          end
        end
      end
      default: ;
    endcase
    r.max_magnitude = table_peak();
    return r;
  endfunction

  // Send one command word, then predict it
  task automatic send_word(stli_pkg::cmd_word_t c);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    start <= 1'b1;
    cmd   <= c;
    // busy seen at the edge is what the block samples
    do @(posedge clk); while (busy);
    expected_words.push_back(apply_command(c));
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stli_pkg::cmd_word_t make_cmd(logic [1:0] k, logic [31:0] key,
                                                   logic [31:0] val, logic [31:0] dv);
    stli_pkg::cmd_word_t c;
    c.kind = k;
    c.key = key;
    c.sample_value = val;
    c.divisor = dv;
    return c;
  endfunction

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (stli_pkg::TABLE_DEPTH + 200) @(posedge clk);
  endtask

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    stli_pkg::result_word_t e;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        unmatched_count++;
        if (mismatch_count + unmatched_count <= 10)
          $display("unexpected result word %h", result);
      end else begin
        e = expected_words.pop_front();
        if (result.result_value !== e.result_value ||
            result.max_magnitude !== e.max_magnitude ||
            result.status !== e.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp val %h max %h st %0d, got val %h max %h st %0d",
                     e.result_value, e.max_magnitude, e.status,
                     result.result_value, result.max_magnitude, result.status);
        end
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Empty-table cases, extremes, duplicates and clamping
  task automatic test_directed();
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h0, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'h0001_0000));
    send_word(make_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h0, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h8000_0000, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h0001_0000, 32'h0003_0000, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h8000_0001, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h0000_8000, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'h0000_0001));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'h8000_0000));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'hFFFF_0000));
    send_word(make_cmd(stli_pkg::KIND_DIVIDE, 32'h0, 32'h0, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, 32'h4000_0000, 32'h0, 32'h0));
    // fill to full, then a new key and a duplicate
    for (int i = 0; i < stli_pkg::TABLE_DEPTH; i++)
      send_word(make_cmd(stli_pkg::KIND_INSERT, $urandom, $urandom, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h0000_0123, 32'h1, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_INSERT, 32'h0001_0000, 32'h1, 32'h0));
    send_word(make_cmd(stli_pkg::KIND_EVAL, $urandom, 32'h0, 32'h0));
    drain();
  endtask

  // Random traffic: a mix of inserts, lookups, divides and unused kinds
  task automatic test_random(int n_items);
    int kind_pick;
    logic [31:0] key;
    for (int i = 0; i < n_items; i++) begin
      kind_pick = $urandom_range(99);
      key = $urandom;
      if (kind_pick < 6) key = $urandom_range(7) << 16;
      if (kind_pick < 40 && tbl_count > 0 && $urandom_range(9) == 0)
        key = tbl_key[$urandom_range(tbl_count - 1)];
      if (kind_pick < 40)
        send_word(make_cmd(stli_pkg::KIND_INSERT, key, $urandom, $urandom));
      else if (kind_pick < 85)
        send_word(make_cmd(stli_pkg::KIND_EVAL, key, $urandom, $urandom));
      else if (kind_pick < 97)
        send_word(make_cmd(stli_pkg::KIND_DIVIDE, key, $urandom,
                           $urandom_range(5) == 0 ? 32'h0 : $urandom));
      else
        send_word(make_cmd(KIND_UNUSED, key, $urandom, $urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    tbl_count = 0;
    mismatch_count = 0;
    unmatched_count = 0;
    cycle_count = 0;
    send_gap_pct = 8;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_gap_pct = 8;
    test_random(550);
    send_gap_pct = 71;
    test_random(550);
    send_gap_pct = 0;
    test_random(550);
    drain();
    if (mismatch_count == 0 && unmatched_count == 0 && expected_words.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
